/* hw/rtl/largest_clean_rectangle_unit_assert.svh */
// Assertion macros shared by the RTL files; both assume ports named clock and reset.
`ifndef LARGEST_CLEAN_RECTANGLE_UNIT_ASSERT_SVH
`define LARGEST_CLEAN_RECTANGLE_UNIT_ASSERT_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define LCR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define LCR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LCR_ASSERT_NOW(lbl, ante, cons, msg)
`define LCR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/lcr_pkg.sv */
package lcr_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;

   // Fixed field widths
   localparam int CFG_W       = 11;
   localparam int AREA_W      = 21;

   localparam int STACK_DEPTH = MAX_WIDTH + 1;
   localparam int HGT_W       = $clog2(MAX_HEIGHT + 1);
   localparam int POS_W       = $clog2(MAX_WIDTH + 1);
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W       = (CFG_W > POS_W) ? CFG_W : POS_W;
   localparam int PROD_W      = ((POS_W + HGT_W) > AREA_W) ? (POS_W + HGT_W) : AREA_W;

   localparam logic [AREA_W-1:0] AREA_LIMIT      = {AREA_W{1'b1}};
   localparam logic [CFG_W-1:0]  ROW_WIDTH_RESET = CFG_W'(1024);

   typedef struct packed {
      logic [HGT_W-1:0] height;
      logic [POS_W-1:0] start;
   } stack_entry_type;

   typedef struct packed {
      logic            push;
      logic            pop;
      stack_entry_type entry;
   } stack_ctrl_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      stack_entry_type  top;
   } stack_stat_type;

endpackage

/* hw/rtl/lcr_stack_cell.sv */
module lcr_stack_cell (
   input  logic                     clock,
   input  lcr_pkg::stack_ctrl_type  ctrl,
   input  lcr_pkg::stack_entry_type above,
   input  lcr_pkg::stack_entry_type below,
   output lcr_pkg::stack_entry_type entry
);
   import lcr_pkg::*;

   stack_entry_type entry_ff;

   // Push moves the stack one cell deeper, pop one cell toward the top.
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         entry_ff <= above;
      end else if (ctrl.pop) begin
         entry_ff <= below;
      end
   end

   assign entry = entry_ff;

endmodule

/* hw/rtl/lcr_cell_chain.sv */
`include "largest_clean_rectangle_unit_assert.svh"

module lcr_cell_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  lcr_pkg::stack_ctrl_type ctrl,
   output lcr_pkg::stack_stat_type stat
);
   import lcr_pkg::*;

   stack_entry_type  cell_q [STACK_DEPTH];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      stack_entry_type above;
      stack_entry_type below;

      if (i == 0) begin : g_head
         assign above = ctrl.entry;
      end else begin : g_body
         assign above = cell_q[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_tail
         assign below = cell_q[i];
      end else begin : g_link
         assign below = cell_q[i+1];
      end

      lcr_stack_cell u_cell (
         .clock (clock),
         .ctrl  (ctrl),
         .above (above),
         .below (below),
         .entry (cell_q[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.count = count_ff;
   assign stat.top   = cell_q[0];

   `LCR_ASSERT_NOW(a_no_push_and_pop, 1'b1, !(ctrl.push && ctrl.pop), "push and pop together")
   `LCR_ASSERT_NOW(a_pop_nonempty, ctrl.pop, count_ff != '0, "pop from empty stack")
   `LCR_ASSERT_NEXT(a_push_lands_on_top, ctrl.push, cell_q[0] == $past(ctrl.entry),
      "pushed entry missing from top cell")

endmodule

/* hw/rtl/largest_clean_rectangle_unit.sv */
// Channel  Ports                                   Transfer
// ------   --------------------------------------  ---------------------------------
// req      start, busy, req_cell_dirty,            start high while busy low
//          req_last_cell
// rsp      rsp_strobe, rsp_max_area                rsp_strobe high, one cycle
// csr      csr_valid, csr_ready, csr_row_width     csr_valid and csr_ready high
//
// A cell is accepted in idle; the settle state pops every stack entry at least as tall as
// the new height, then pushes; a row-end cell then goes to the flush state, which pops
// all entries left. Each entry is pushed and popped once, paced by the single push-or-pop
// per cycle of the stack cell chain. Reset is synchronous and needs no clearing pass:
// column heights beyond the highest column written in the current matrix read as zero.
// The last cell's result is on rsp_strobe as the block drops busy; the receiver cannot stall.

`include "largest_clean_rectangle_unit_assert.svh"

module largest_clean_rectangle_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_cell_dirty,
   input  logic                        req_last_cell,
   output logic                        rsp_strobe,
   output logic [lcr_pkg::AREA_W-1:0]  rsp_max_area,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lcr_pkg::CFG_W-1:0]   csr_row_width
);
   import lcr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETTLE,
      ST_FLUSH
   } state_type;

   state_type        state_ff, state_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [AREA_W-1:0] rsp_area_ff, rsp_area_in;
   logic [COL_W-1:0] column_index_ff, column_index_in;
   logic             fill_valid_ff, fill_valid_in;
   logic [COL_W-1:0] fill_hi_ff, fill_hi_in;
   logic [AREA_W-1:0] best_ff, best_in;
   logic [CFG_W-1:0] row_width_ff, row_width_in;

   // Item registers
   logic             dirty_ff;
   logic             last_ff;
   logic             row_end_ff;
   logic             hit_ff;
   logic [COL_W-1:0] col_ff;
   logic [POS_W-1:0] start_pos_ff;

   logic [HGT_W-1:0] heights_mem [MAX_WIDTH];
   logic [HGT_W-1:0] rdata_ff;
   logic             mem_we;

   stack_ctrl_type   ctrl;
   stack_stat_type   stat;

   logic             accept;
   logic [CMP_W-1:0] row_width_ext;
   logic [CMP_W-1:0] eff_width;
   logic             row_end;
   logic [HGT_W:0]   rd_sum;
   logic [HGT_W-1:0] h_cur;
   logic [POS_W-1:0] pos_cur;
   logic [AREA_W-1:0] area_now;
   logic             stack_has_room;

   function automatic logic [AREA_W-1:0] clip_area(input logic [HGT_W-1:0] h,
                                                   input logic [POS_W-1:0] s,
                                                   input logic [POS_W-1:0] p);
      logic [POS_W-1:0]  span;
      logic [PROD_W-1:0] prod;
      span = (p >= s) ? (p - s) : '0;
      prod = PROD_W'(span) * PROD_W'(h);
      if (prod > PROD_W'(AREA_LIMIT)) begin
         return AREA_LIMIT;
      end
      return AREA_W'(prod);
   endfunction

   assign busy      = (state_ff != ST_IDLE) || reset;
   assign accept    = start && !busy;
   assign csr_ready = !reset;

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_max_area = rsp_area_ff;

   // Width 0 acts as 1, anything past the maximum as the maximum.
   assign row_width_ext = CMP_W'(row_width_ff);
   always_comb begin
      if (row_width_ext == '0) begin
         eff_width = CMP_W'(1);
      end else if (row_width_ext > CMP_W'(MAX_WIDTH)) begin
         eff_width = CMP_W'(MAX_WIDTH);
      end else begin
         eff_width = row_width_ext;
      end
   end

   assign row_end = req_last_cell ||
                    ((CMP_W'(column_index_ff) + CMP_W'(1)) >= eff_width);

   // Column height for the current cell, saturating at the maximum.
   assign rd_sum = {1'b0, rdata_ff} + (HGT_W+1)'(1);
   always_comb begin
      if (dirty_ff) begin
         h_cur = '0;
      end else if (!hit_ff) begin
         h_cur = HGT_W'(1);
      end else if (rd_sum > (HGT_W+1)'(MAX_HEIGHT)) begin
         h_cur = HGT_W'(MAX_HEIGHT);
      end else begin
         h_cur = rd_sum[HGT_W-1:0];
      end
   end

   assign pos_cur  = (state_ff == ST_FLUSH) ? (POS_W'(col_ff) + POS_W'(1)) : POS_W'(col_ff);
   assign area_now = clip_area(stat.top.height, stat.top.start, pos_cur);
   assign stack_has_room = (stat.count != CNT_W'(STACK_DEPTH));

   always_comb begin
      state_in           = state_ff;
      rsp_strobe_in      = 1'b0;
      rsp_area_in        = rsp_area_ff;
      column_index_in    = column_index_ff;
      fill_valid_in      = fill_valid_ff;
      fill_hi_in         = fill_hi_ff;
      best_in            = best_ff;
      row_width_in       = row_width_ff;
      mem_we             = 1'b0;
      ctrl.push          = 1'b0;
      ctrl.pop           = 1'b0;
      ctrl.entry.height  = h_cur;
      ctrl.entry.start   = start_pos_ff;

      if (csr_valid) begin
         row_width_in = csr_row_width;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            if ((stat.count != '0) && (stat.top.height >= h_cur)) begin
               ctrl.pop = 1'b1;
               if (area_now > best_ff) begin
                  best_in = area_now;
               end
            end else begin
               ctrl.push = stack_has_room;
               mem_we    = 1'b1;
               if (!fill_valid_ff || (col_ff > fill_hi_ff)) begin
                  fill_valid_in = 1'b1;
                  fill_hi_in    = col_ff;
               end
               if (row_end_ff) begin
                  state_in = ST_FLUSH;
               end else begin
                  column_index_in = col_ff + COL_W'(1);
                  state_in        = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            // Height-0 sentinel pops every entry.
            if (stat.count != '0) begin
               ctrl.pop = 1'b1;
               if (area_now > best_ff) begin
                  best_in = area_now;
               end
            end else begin
               column_index_in = '0;
               state_in        = ST_IDLE;
               if (last_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_area_in   = best_ff;
                  best_in       = '0;
                  fill_valid_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_area_ff <= rsp_area_in;
      fill_hi_ff  <= fill_hi_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_strobe_ff   <= 1'b0;
         column_index_ff <= '0;
         fill_valid_ff   <= 1'b0;
         best_ff         <= '0;
         row_width_ff    <= ROW_WIDTH_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_strobe_ff   <= rsp_strobe_in;
         column_index_ff <= column_index_in;
         fill_valid_ff   <= fill_valid_in;
         best_ff         <= best_in;
         row_width_ff    <= row_width_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dirty_ff     <= req_cell_dirty;
         last_ff      <= req_last_cell;
         row_end_ff   <= row_end;
         hit_ff       <= fill_valid_ff && (column_index_ff <= fill_hi_ff);
         col_ff       <= column_index_ff;
         start_pos_ff <= POS_W'(column_index_ff);
      end else if ((state_ff == ST_SETTLE) && ctrl.pop) begin
         // Widen the pending entry back to the popped start.
         start_pos_ff <= stat.top.start;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rdata_ff <= heights_mem[column_index_ff];
      end
      if (mem_we) begin
         heights_mem[col_ff] <= h_cur;
      end
   end

   lcr_cell_chain u_chain (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   `LCR_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "accepted cell did not raise busy")
   `LCR_ASSERT_NOW(a_rsp_after_flush, rsp_strobe_ff,
      (stat.count == '0) && (column_index_ff == '0) && (best_ff == '0),
      "result given before matrix state was cleared")
   `LCR_ASSERT_NOW(a_fill_starts_at_zero, ctrl.push && !fill_valid_ff, col_ff == '0,
      "first column of a matrix is not column zero")
   `LCR_ASSERT_NOW(a_fill_contiguous, ctrl.push && fill_valid_ff && (col_ff > fill_hi_ff),
      col_ff == (fill_hi_ff + COL_W'(1)), "column heights written out of order")

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import lcr_pkg::*;

   class rect_area_scoreboard;
      bit [CFG_W-1:0]  row_width;
      bit [HGT_W-1:0]  col_height [MAX_WIDTH];
      bit [HGT_W-1:0]  stk_height [STACK_DEPTH];
      bit [POS_W-1:0]  stk_start  [STACK_DEPTH];
      int unsigned     stk_count;
      bit [COL_W-1:0]  col_pos;
      bit [AREA_W-1:0] best_area;
      bit [AREA_W-1:0] expected_areas [$];
      int              failures;

      function new();
         row_width = ROW_WIDTH_RESET;
         failures  = 0;
         clear_matrix();
      endfunction

      function void clear_matrix();
         foreach (col_height[i]) col_height[i] = '0;
         best_area = '0;
         stk_count = 0;
         col_pos   = '0;
      endfunction

      function void set_width(bit [CFG_W-1:0] value);
         row_width = value;
      endfunction

      function int pending();
         return expected_areas.size();
      endfunction

      function void note_span(int unsigned h, int unsigned span_start, int unsigned pos);
         int unsigned area;
         area = (pos >= span_start) ? (pos - span_start) * h : 0;
         if (area > AREA_LIMIT) area = AREA_LIMIT;
         if (area > best_area) best_area = area[AREA_W-1:0];
      endfunction

      // Pop every entry at least as tall as h; return where the merged run begins.
      function int unsigned settle_stack(int unsigned h, int unsigned pos);
         int unsigned span_start;
         span_start = pos;
         while (stk_count > 0 && stk_count <= STACK_DEPTH) begin
            if (stk_height[stk_count-1] < h) break;
            note_span(32'(stk_height[stk_count-1]), 32'(stk_start[stk_count-1]), pos);
            span_start = 32'(stk_start[stk_count-1]);
            stk_count--;
         end
         return span_start;
      endfunction

      function void note_cell(bit dirty, bit last);
         int unsigned w, c, h, span_start;
         w = 32'(row_width);
         if (w < 1) w = 1;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         c = 32'(col_pos);
         if (dirty) begin
            h = 0;
         end else begin
            h = 32'(col_height[c]) + 1;
            if (h > MAX_HEIGHT) h = MAX_HEIGHT;
         end
         col_height[c] = h[HGT_W-1:0];
         span_start = settle_stack(h, c);
         if (stk_count < STACK_DEPTH) begin
            stk_height[stk_count] = h[HGT_W-1:0];
            stk_start[stk_count]  = span_start[POS_W-1:0];
            stk_count++;
         end
         // End of row, or a partial row cut short by the last cell: flush with height 0.
         if (last || c + 1 >= w) begin
            void'(settle_stack(0, c + 1));
            stk_count = 0;
            col_pos   = '0;
         end else begin
            col_pos = COL_W'(c + 1);
         end
         if (last) begin
            expected_areas.push_back(best_area);
            clear_matrix();
         end
      endfunction

      function void check_area(bit [AREA_W-1:0] actual);
         bit [AREA_W-1:0] want;
         if (expected_areas.size() == 0) begin
            failures++;
            if (failures <= 10) $display("unexpected area result: got %0d", actual);
         end else begin
            want = expected_areas.pop_front();
            if (want != actual) begin
               failures++;
               if (failures <= 10)
                  $display("max_area mismatch: expected %0d, got %0d", want, actual);
            end
         end
      endfunction
   endclass

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              start          = 1'b0;
   logic              busy;
   logic              req_cell_dirty = 1'b0;
   logic              req_last_cell  = 1'b0;
   logic              rsp_strobe;
   logic [AREA_W-1:0] rsp_max_area;
   logic              csr_valid      = 1'b0;
   logic              csr_ready;
   logic [CFG_W-1:0]  csr_row_width  = '0;

   rect_area_scoreboard sb = new();
   int                  cur_width    = MAX_WIDTH;
   int                  idle_pct     = 0;
   int                  results_seen = 0;

   largest_clean_rectangle_unit dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cell_dirty(req_cell_dirty),
      .req_last_cell (req_last_cell),
      .rsp_strobe    (rsp_strobe),
      .rsp_max_area  (rsp_max_area),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_row_width (csr_row_width)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_width(csr_row_width);
         if (start && !busy) sb.note_cell(req_cell_dirty, req_last_cell);
         if (rsp_strobe) begin
            sb.check_area(rsp_max_area);
            results_seen++;
         end
      end
   end

   // Present one cell and hold it until the transfer; returns on the transfer edge.
   task automatic send_cell(input bit dirty, input bit last);
      int gap;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(8, 1);
         start          <= 1'b0;
         req_cell_dirty <= 1'($urandom);
         req_last_cell  <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_cell_dirty <= dirty;
      req_last_cell  <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start, wait for outstanding areas, then let any row flush finish.
   task automatic wait_idle();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(posedge clock);
      while (busy) @(posedge clock);
      repeat (3 * cur_width + 8) @(posedge clock);
   endtask

   task automatic write_width(input logic [CFG_W-1:0] value);
      repeat ($urandom_range(3)) @(posedge clock);
      csr_valid     <= 1'b1;
      csr_row_width <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_width = (value == 0) ? 1 : ((value > MAX_WIDTH) ? MAX_WIDTH : int'(value));
   endtask

   initial begin
      int               n, rows, dirty_pct, pick, rand_items, results_base, cut_at, change_at;
      logic [CFG_W-1:0] w;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset width, matrix ended mid-row.
      idle_pct = 30;
      send_cell(1'b0, 1'b0);
      send_cell(1'b1, 1'b0);
      send_cell(1'b0, 1'b0);
      send_cell(1'b0, 1'b1);
      wait_idle();

      // Width 0 acts as 1: one tall column, dirty last cell.
      write_width('0);
      repeat (3) send_cell(1'b0, 1'b0);
      send_cell(1'b1, 1'b1);
      wait_idle();

      // Width above the maximum clamps.
      write_width({CFG_W{1'b1}});
      send_cell(1'b0, 1'b0);
      send_cell(1'b0, 1'b1);
      wait_idle();

      // Full 3x3 matrix.
      write_width(CFG_W'(3));
      send_cell(1'b0, 1'b0); send_cell(1'b1, 1'b0); send_cell(1'b0, 1'b0);
      send_cell(1'b0, 1'b0); send_cell(1'b0, 1'b0); send_cell(1'b0, 1'b0);
      send_cell(1'b1, 1'b0); send_cell(1'b0, 1'b0); send_cell(1'b0, 1'b1);
      wait_idle();

      // Shrink the width while the column position is past the new row end.
      send_cell(1'b0, 1'b0);
      send_cell(1'b0, 1'b0);
      wait_idle();
      write_width(CFG_W'(2));
      send_cell(1'b0, 1'b0);
      send_cell(1'b0, 1'b0);
      send_cell(1'b0, 1'b1);
      wait_idle();

      // Column taller than the height limit.
      write_width(CFG_W'(1));
      idle_pct = 10;
      send_cell(1'($urandom_range(1)), 1'b0);
      for (int i = 0; i < MAX_HEIGHT + 16; i++) send_cell(1'b0, i == MAX_HEIGHT + 15);
      wait_idle();

      rand_items   = 0;
      results_base = results_seen;
      while (rand_items < 620 || results_seen - results_base < 40) begin
         if ($urandom_range(99) < 70) begin
            pick = $urandom_range(99);
            if (pick < 60)      w = CFG_W'($urandom_range(8, 1));
            else if (pick < 80) w = CFG_W'($urandom_range(32, 9));
            else if (pick < 85) w = '0;
            else if (pick < 90) w = CFG_W'(MAX_WIDTH);
            else if (pick < 95) w = CFG_W'($urandom_range(2047, MAX_WIDTH + 1));
            else                w = {CFG_W{1'b1}};
            write_width(w);
         end
         if (cur_width > 32) begin
            n = $urandom_range(24, 1);
         end else begin
            rows = (cur_width <= 8) ? $urandom_range(6, 1) : $urandom_range(2, 1);
            n    = rows * cur_width;
         end
         // Broken sequences: an early last cell, or a width change partway through.
         cut_at    = ($urandom_range(99) < 15) ? $urandom_range(n - 1) : n - 1;
         change_at = ($urandom_range(99) < 10) ? $urandom_range(cut_at) : -1;
         dirty_pct = $urandom_range(4) * 25;
         pick      = $urandom_range(2);
         idle_pct  = (rand_items >= 470) ? 0 : ((pick == 0) ? 0 : ((pick == 1) ? 20 : 60));
         for (int i = 0; i <= cut_at; i++) begin
            if (i == change_at && i != 0) begin
               wait_idle();
               write_width(CFG_W'($urandom_range(8, 1)));
            end
            send_cell($urandom_range(99) < dirty_pct, i == cut_at);
         end
         rand_items += cut_at + 1;
         wait_idle();
      end

      if (sb.failures == 0 && sb.pending() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/lcr_pkg.sv
hw/rtl/lcr_stack_cell.sv
hw/rtl/lcr_cell_chain.sv
hw/rtl/largest_clean_rectangle_unit.sv
dv/testbench.sv
